/* rtl/ffha_pkg.sv */
package ffha_pkg;

    // Sizing of the block table and of the address space
    localparam int TABLE_DEPTH  = 64;
    localparam int ADDR_BITS    = 24;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int TOP_W   = ADDR_BITS + 1;
    localparam int LIMIT_W = 25;
    localparam int CMP_W   = ((TOP_W > LIMIT_W) ? TOP_W : LIMIT_W) + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;

    // Word index of heap_limit in the register space (paddr[2])
    localparam logic REG_HEAP_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_HEAP    = 3'd2,
        ST_TABLE   = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_FIT,
        S_RELEASE
    } state_t;

    // One table entry: data address (header start plus header), size, free mark
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the request fields
        logic scan_look;  // start a search for the in-use block at the request address
        logic scan_fit;   // start a first-fit search for a free block
        logic use_hit;    // mark the block under evaluation in use
        logic append;     // grow the heap by a new block
        logic rel_old;    // release the block found by the address search
        logic keep_old;   // grant the request address as it stands
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic old_fits;
        logic heap_fail;
        logic table_full;
    } dp_status_t;

endpackage

/* rtl/ffha_datapath.sv */
module ffha_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ffha_pkg::dp_cmd_t                      dp_cmd,
    output ffha_pkg::dp_status_t                   dp_status,
    input  logic [ffha_pkg::ADDR_BITS-1:0]         req_size,
    input  logic [ffha_pkg::ADDR_BITS-1:0]         block_addr,
    input  logic [ffha_pkg::LIMIT_W-1:0]           heap_limit,
    output logic [ffha_pkg::ADDR_BITS-1:0]         result_addr
);

    localparam logic [ffha_pkg::CMP_W-1:0] HEAP_CAP =
        ffha_pkg::CMP_W'(1) << ffha_pkg::ADDR_BITS;

    ffha_pkg::entry_t                     mem [ffha_pkg::TABLE_DEPTH];
    ffha_pkg::entry_t                     rdata_reg;

    logic [ffha_pkg::ADDR_BITS-1:0]       req_size_reg;
    logic [ffha_pkg::ADDR_BITS-1:0]       req_addr_reg;
    logic [ffha_pkg::ADDR_BITS-1:0]       res_reg;
    logic [ffha_pkg::ADDR_BITS-1:0]       res_next;
    logic [ffha_pkg::IDX_W-1:0]           old_idx_reg;
    logic [ffha_pkg::ADDR_BITS-1:0]       old_size_reg;

    logic [ffha_pkg::CNT_W-1:0]           count_reg;
    logic [ffha_pkg::CNT_W-1:0]           count_next;
    logic [ffha_pkg::TOP_W-1:0]           top_reg;
    logic [ffha_pkg::TOP_W-1:0]           top_next;

    logic                                 scanning_reg;
    logic                                 look_mode_reg;
    logic                                 ev_valid_reg;
    logic [ffha_pkg::IDX_W-1:0]           ev_idx_reg;
    logic [ffha_pkg::CNT_W-1:0]           rd_idx_reg;

    logic                                 more;
    logic                                 ev_match;
    logic                                 scan_hit;
    logic                                 scan_miss;
    logic                                 old_is_top;

    logic [ffha_pkg::CMP_W-1:0]           new_top;
    logic [ffha_pkg::CMP_W-1:0]           limit_ext;
    logic [ffha_pkg::CMP_W-1:0]           eff_limit;

    logic                                 we;
    logic [ffha_pkg::IDX_W-1:0]           wr_idx;
    ffha_pkg::entry_t                     wr_word;

    // Search control
    assign more     = rd_idx_reg < count_reg;
    assign ev_match = look_mode_reg
                    ? (!rdata_reg.free && (rdata_reg.addr == req_addr_reg))
                    : (rdata_reg.free && (rdata_reg.size >= req_size_reg));
    assign scan_hit  = scanning_reg && ev_valid_reg && ev_match;
    assign scan_miss = scanning_reg && !ev_valid_reg && !more;

    // Growth checks
    assign new_top   = ffha_pkg::CMP_W'(top_reg) + ffha_pkg::CMP_W'(ffha_pkg::HEADER_BYTES)
                     + ffha_pkg::CMP_W'(req_size_reg);
    assign limit_ext = ffha_pkg::CMP_W'(heap_limit);
    assign eff_limit = (limit_ext < HEAP_CAP) ? limit_ext : HEAP_CAP;

    assign old_is_top = (ffha_pkg::CNT_W'(old_idx_reg) + ffha_pkg::CNT_W'(1)) == count_reg;

    assign dp_status.scan_hit   = scan_hit;
    assign dp_status.scan_miss  = scan_miss;
    assign dp_status.old_fits   = rdata_reg.size >= req_size_reg;
    assign dp_status.heap_fail  = new_top > eff_limit;
    assign dp_status.table_full = count_reg >= ffha_pkg::CNT_W'(ffha_pkg::TABLE_DEPTH);

    assign result_addr = res_reg;

    // Table write port, heap top, count and granted address
    always_comb
    begin
        we         = 1'b0;
        wr_idx     = ev_idx_reg;
        wr_word    = rdata_reg;
        count_next = count_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        if (dp_cmd.load)
        begin
            res_next = '0;
        end
        if (dp_cmd.use_hit)
        begin
            we           = 1'b1;
            wr_idx       = ev_idx_reg;
            wr_word      = rdata_reg;
            wr_word.free = 1'b0;
            res_next     = rdata_reg.addr;
        end
        else if (dp_cmd.append)
        begin
            we           = 1'b1;
            wr_idx       = count_reg[ffha_pkg::IDX_W-1:0];
            wr_word.addr = ffha_pkg::ADDR_BITS'(top_reg
                           + ffha_pkg::TOP_W'(ffha_pkg::HEADER_BYTES));
            wr_word.size = req_size_reg;
            wr_word.free = 1'b0;
            count_next   = count_reg + ffha_pkg::CNT_W'(1);
            top_next     = ffha_pkg::TOP_W'(new_top);
            res_next     = wr_word.addr;
        end
        else if (dp_cmd.rel_old)
        begin
            if (old_is_top)
            begin
                count_next = count_reg - ffha_pkg::CNT_W'(1);
                top_next   = top_reg - (ffha_pkg::TOP_W'(old_size_reg)
                             + ffha_pkg::TOP_W'(ffha_pkg::HEADER_BYTES));
            end
            else
            begin
                we           = 1'b1;
                wr_idx       = old_idx_reg;
                wr_word.addr = req_addr_reg;
                wr_word.size = old_size_reg;
                wr_word.free = 1'b1;
            end
        end
        else if (dp_cmd.keep_old)
        begin
            res_next = req_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (scanning_reg && more)
        begin
            rdata_reg <= mem[rd_idx_reg[ffha_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (dp_cmd.load)
        begin
            req_size_reg <= req_size;
            req_addr_reg <= block_addr;
        end
        if (scan_hit && look_mode_reg)
        begin
            old_idx_reg  <= ev_idx_reg;
            old_size_reg <= rdata_reg.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            top_reg       <= '0;
            scanning_reg  <= 1'b0;
            look_mode_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            ev_idx_reg    <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            top_reg   <= top_next;
            if (dp_cmd.scan_look || dp_cmd.scan_fit)
            begin
                scanning_reg  <= 1'b1;
                look_mode_reg <= dp_cmd.scan_look;
                ev_valid_reg  <= 1'b0;
                rd_idx_reg    <= '0;
            end
            else if (scanning_reg)
            begin
                if (scan_hit || scan_miss)
                begin
                    scanning_reg <= 1'b0;
                    ev_valid_reg <= 1'b0;
                end
                else
                begin
                    ev_valid_reg <= more;
                    if (more)
                    begin
                        ev_idx_reg <= rd_idx_reg[ffha_pkg::IDX_W-1:0];
                        rd_idx_reg <= rd_idx_reg + ffha_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

endmodule

/* rtl/ffha_ctrl.sv */
module ffha_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             cmd,
    input  logic                   size_zero,
    input  logic                   addr_zero,
    input  ffha_pkg::dp_status_t   dp_status,
    output ffha_pkg::dp_cmd_t      dp_cmd,
    output logic                   busy,
    output logic                   done,
    output logic [2:0]             status
);

    ffha_pkg::state_t   state_reg;
    ffha_pkg::state_t   state_next;
    logic               realloc_reg;
    logic               realloc_next;
    logic               done_reg;
    ffha_pkg::status_t  status_reg;
    logic               finish;
    ffha_pkg::status_t  fin_status;

    assign busy   = state_reg != ffha_pkg::S_IDLE;
    assign done   = done_reg;
    assign status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ffha_pkg::S_IDLE;
            realloc_reg <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= ffha_pkg::ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            realloc_reg <= realloc_next;
            done_reg    <= finish;
            if (finish)
            begin
                status_reg <= fin_status;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        realloc_next = realloc_reg;
        dp_cmd       = '0;
        finish       = 1'b0;
        fin_status   = ffha_pkg::ST_OK;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load  = 1'b1;
                    realloc_next = 1'b0;
                    unique case (cmd)
                        ffha_pkg::CMD_ALLOC:
                        begin
                            if (size_zero)
                            begin
                                finish     = 1'b1;
                                fin_status = ffha_pkg::ST_NULL;
                            end
                            else
                            begin
                                dp_cmd.scan_fit = 1'b1;
                                state_next      = ffha_pkg::S_FIT;
                            end
                        end
                        ffha_pkg::CMD_FREE:
                        begin
                            if (addr_zero)
                            begin
                                finish     = 1'b1;
                                fin_status = ffha_pkg::ST_NULL;
                            end
                            else
                            begin
                                dp_cmd.scan_look = 1'b1;
                                state_next       = ffha_pkg::S_LOOK;
                            end
                        end
                        ffha_pkg::CMD_REALLOC:
                        begin
                            if (size_zero)
                            begin
                                finish     = 1'b1;
                                fin_status = ffha_pkg::ST_NULL;
                            end
                            else if (addr_zero)
                            begin
                                dp_cmd.scan_fit = 1'b1;
                                state_next      = ffha_pkg::S_FIT;
                            end
                            else
                            begin
                                dp_cmd.scan_look = 1'b1;
                                realloc_next     = 1'b1;
                                state_next       = ffha_pkg::S_LOOK;
                            end
                        end
                        default:
                        begin
                            finish     = 1'b1;
                            fin_status = ffha_pkg::ST_NULL;
                        end
                    endcase
                end
            end
            ffha_pkg::S_LOOK:
            begin
                if (dp_status.scan_hit)
                begin
                    if (!realloc_reg)
                    begin
                        state_next = ffha_pkg::S_RELEASE;
                    end
                    else if (dp_status.old_fits)
                    begin
                        dp_cmd.keep_old = 1'b1;
                        finish          = 1'b1;
                        state_next      = ffha_pkg::S_IDLE;
                    end
                    else
                    begin
                        dp_cmd.scan_fit = 1'b1;
                        state_next      = ffha_pkg::S_FIT;
                    end
                end
                else if (dp_status.scan_miss)
                begin
                    finish     = 1'b1;
                    fin_status = ffha_pkg::ST_UNKNOWN;
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            ffha_pkg::S_FIT:
            begin
                if (dp_status.scan_hit)
                begin
                    dp_cmd.use_hit = 1'b1;
                    if (realloc_reg)
                    begin
                        state_next = ffha_pkg::S_RELEASE;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = ffha_pkg::S_IDLE;
                    end
                end
                else if (dp_status.scan_miss)
                begin
                    if (dp_status.heap_fail)
                    begin
                        finish     = 1'b1;
                        fin_status = ffha_pkg::ST_HEAP;
                        state_next = ffha_pkg::S_IDLE;
                    end
                    else if (dp_status.table_full)
                    begin
                        finish     = 1'b1;
                        fin_status = ffha_pkg::ST_TABLE;
                        state_next = ffha_pkg::S_IDLE;
                    end
                    else
                    begin
                        dp_cmd.append = 1'b1;
                        if (realloc_reg)
                        begin
                            state_next = ffha_pkg::S_RELEASE;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            state_next = ffha_pkg::S_IDLE;
                        end
                    end
                end
            end
            ffha_pkg::S_RELEASE:
            begin
                dp_cmd.rel_old = 1'b1;
                finish         = 1'b1;
                state_next     = ffha_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/first_fit_heap_allocator_core.sv */
// Channel    Transfer when                        Payload
// ---------  -----------------------------------  ---------------------------------
// request    start & !busy at a rising edge       cmd, req_size, block_addr
// result     done high for one cycle              result_addr, status
// config     psel & penable & pwrite (pready = 1) pwdata -> heap_limit (paddr[2] 0)
//
// A request walks the block table one entry a cycle through its single read
// port for each search: an alloc runs one first-fit search, a free one
// address search, a realloc up to both. Null, zero-size and unused-command
// requests answer in the cycle after they are taken.
// Reset clears the block count, the heap top and the controller; the table
// itself is not cleared, only entries below the count are ever read.
// The result strobe cannot be held off; busy drops in the cycle it shows.
module first_fit_heap_allocator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // request
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [ffha_pkg::ADDR_BITS-1:0]      req_size,
    input  logic [ffha_pkg::ADDR_BITS-1:0]      block_addr,
    // result
    output logic                                done,
    output logic [ffha_pkg::ADDR_BITS-1:0]      result_addr,
    output logic [2:0]                          status,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [ffha_pkg::LIMIT_W-1:0]  heap_limit_reg;
    logic                          cfg_wr;
    ffha_pkg::dp_cmd_t             dp_cmd;
    ffha_pkg::dp_status_t          dp_status;

    // Configuration port: zero-wait, writes land at the access phase;
    // heap_limit is the only register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ffha_pkg::REG_HEAP_LIMIT);
    assign prdata = (paddr[2] == ffha_pkg::REG_HEAP_LIMIT) ? 32'(heap_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= ffha_pkg::LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            heap_limit_reg <= pwdata[ffha_pkg::LIMIT_W-1:0];
        end
    end

    // Sequencing: decode the request, run the searches, issue table updates
    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .size_zero (req_size == '0),
        .addr_zero (block_addr == '0),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd),
        .busy      (busy),
        .done      (done),
        .status    (status)
    );

    // Block table, heap top, block count and the growth checks
    ffha_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .req_size    (req_size),
        .block_addr  (block_addr),
        .heap_limit  (heap_limit_reg),
        .result_addr (result_addr)
    );

endmodule

/* rtl/ffha_checker.sv */
module ffha_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [ffha_pkg::ADDR_BITS-1:0]      req_size,
    input  logic [ffha_pkg::ADDR_BITS-1:0]      block_addr,
    input  logic                                done,
    input  logic [ffha_pkg::ADDR_BITS-1:0]      result_addr,
    input  logic [2:0]                          status
);

    // A result only shows once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Any failure grants no address
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ffha_pkg::ST_OK)) |-> (result_addr == '0))
        else $error("failed request granted an address");

    // A zero-size alloc answers at once
    a_zero_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == ffha_pkg::CMD_ALLOC) && (req_size == '0))
        |=> (done && (status == ffha_pkg::ST_NULL)))
        else $error("zero-size alloc not answered at once");

    // A free of null answers at once
    a_null_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == ffha_pkg::CMD_FREE) && (block_addr == '0))
        |=> (done && (status == ffha_pkg::ST_NULL) && (result_addr == '0)))
        else $error("free of null not answered at once");

    // A real free must search the table before answering
    a_free_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == ffha_pkg::CMD_FREE) && (block_addr != '0))
        |=> (busy && !done))
        else $error("free answered without a table search");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .req_size    (req_size),
    .block_addr  (block_addr),
    .done        (done),
    .result_addr (result_addr),
    .status      (status)
);

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [ffha_pkg::ADDR_BITS-1:0] addr_t;

    // Unused command code: the block answers it as a null request
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    // Byte address of heap_limit
    localparam logic [2:0] HEAP_LIMIT_ADDR = {ffha_pkg::REG_HEAP_LIMIT, 2'b00};
    localparam int         CYCLE_LIMIT     = 1_000_000;
    // Longest request walks the table twice and passes its control states
    localparam int         SETTLE_CYCLES   = 2 * ffha_pkg::TABLE_DEPTH + 8;

    // One expected answer from the allocator
    typedef struct {
        addr_t             addr;
        ffha_pkg::status_t st;
    } grant_t;

    // One row of the opening script; known rows carry a hand-typed answer
    typedef struct {
        logic [1:0]        op;
        addr_t             size;
        addr_t             addr;
        bit                known;
        addr_t             exp_addr;
        ffha_pkg::status_t exp_st;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    addr_t       req_size;
    addr_t       block_addr;
    logic        done;
    addr_t       result_addr;
    logic [2:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    first_fit_heap_allocator_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .req_size    (req_size),
        .block_addr  (block_addr),
        .done        (done),
        .result_addr (result_addr),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the allocator state, advanced once per accepted transfer
    // ------------------------------------------------------------------
    addr_t                        blk_hdr  [ffha_pkg::TABLE_DEPTH];  // header start
    addr_t                        blk_len  [ffha_pkg::TABLE_DEPTH];  // data size
    logic                         blk_idle [ffha_pkg::TABLE_DEPTH];  // free mark
    logic [ffha_pkg::CNT_W-1:0]   blk_cnt   = '0;
    logic [ffha_pkg::TOP_W-1:0]   top_now   = '0;
    logic [ffha_pkg::LIMIT_W-1:0] limit_now = ffha_pkg::LIMIT_RESET;

    grant_t      pending_grants[$];   // answers still owed by the block, oldest first
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int          idle_pct    = 0;     // chance in a hundred that the sender holds off again before offering

    // Hand-typed answers appear only where the allocator state makes them obvious:
    // null and zero requests, the heap ceiling at its reset value, an empty heap.
    script_row_t opening_script[24] = '{
        // null requests and the unused command
        '{ffha_pkg::CMD_ALLOC,   24'h000000, 24'h000000, 1'b1, 24'd0,  ffha_pkg::ST_NULL},
        '{ffha_pkg::CMD_FREE,    24'h000000, 24'h000000, 1'b1, 24'd0,  ffha_pkg::ST_NULL},
        '{CMD_UNUSED,            24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'd0,  ffha_pkg::ST_NULL},
        // largest request overshoots the 16 MiB ceiling once its header is added
        '{ffha_pkg::CMD_ALLOC,   24'hFFFFFF, 24'h000000, 1'b1, 24'd0,  ffha_pkg::ST_HEAP},
        // request that lands exactly on the ceiling
        '{ffha_pkg::CMD_ALLOC,   24'hFFFFF0, 24'h000000, 1'b1, 24'd16, ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_ALLOC,   24'h000001, 24'h000000, 1'b1, 24'd0,  ffha_pkg::ST_HEAP},
        // realloc that cannot grow leaves the old block in use
        '{ffha_pkg::CMD_REALLOC, 24'hFFFFFF, 24'd16,     1'b1, 24'd0,  ffha_pkg::ST_HEAP},
        '{ffha_pkg::CMD_REALLOC, 24'h00000A, 24'd16,     1'b1, 24'd16, ffha_pkg::ST_OK},
        // free of the top block empties the heap, a second free is unknown
        '{ffha_pkg::CMD_FREE,    24'h000000, 24'd16,     1'b1, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_FREE,    24'h000000, 24'd16,     1'b1, 24'd0,  ffha_pkg::ST_UNKNOWN},
        '{ffha_pkg::CMD_REALLOC, 24'h000000, 24'h000000, 1'b1, 24'd0,  ffha_pkg::ST_NULL},
        '{ffha_pkg::CMD_ALLOC,   24'd100,    24'h000000, 1'b1, 24'd16, ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_ALLOC,   24'd50,     24'h000000, 1'b0, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_ALLOC,   24'd8,      24'h000000, 1'b0, 24'd0,  ffha_pkg::ST_OK},
        // free below the top only marks the block; next fit reuses it
        '{ffha_pkg::CMD_FREE,    24'h000000, 24'd16,     1'b0, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_ALLOC,   24'd90,     24'h000000, 1'b0, 24'd0,  ffha_pkg::ST_OK},
        // address into the middle of a block
        '{ffha_pkg::CMD_FREE,    24'h000000, 24'd20,     1'b1, 24'd0,  ffha_pkg::ST_UNKNOWN},
        // realloc of null behaves as an alloc
        '{ffha_pkg::CMD_REALLOC, 24'd30,     24'h000000, 1'b0, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_REALLOC, 24'h000000, 24'd132,    1'b1, 24'd0,  ffha_pkg::ST_NULL},
        // realloc that moves, then the old address is gone
        '{ffha_pkg::CMD_REALLOC, 24'd200,    24'd132,    1'b0, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_REALLOC, 24'd10,     24'd132,    1'b0, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_FREE,    24'h000000, 24'hFFFFFF, 1'b1, 24'd0,  ffha_pkg::ST_UNKNOWN},
        '{ffha_pkg::CMD_ALLOC,   24'h000001, 24'h000000, 1'b0, 24'd0,  ffha_pkg::ST_OK},
        '{ffha_pkg::CMD_REALLOC, 24'h800000, 24'd16,     1'b0, 24'd0,  ffha_pkg::ST_OK}
    };

    // ------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------

    // Index of the in-use block whose data starts at a, or -1
    function automatic int find_live(input addr_t a);
        int i;
        for (i = 0; i < int'(blk_cnt); i++)
            if (!blk_idle[i] && (ffha_pkg::TOP_W'(blk_hdr[i])
                                 + ffha_pkg::TOP_W'(ffha_pkg::HEADER_BYTES)
                                 == ffha_pkg::TOP_W'(a)))
                return i;
        return -1;
    endfunction

    // Top block shrinks the heap; any other block is only marked free
    function automatic void retire_block(input int idx);
        if (idx + 1 == int'(blk_cnt))
        begin
            top_now = top_now - (ffha_pkg::TOP_W'(blk_len[idx])
                                 + ffha_pkg::TOP_W'(ffha_pkg::HEADER_BYTES));
            blk_cnt = blk_cnt - ffha_pkg::CNT_W'(1);
        end
        else
        begin
            blk_idle[idx] = 1'b1;
        end
    endfunction

    // First fit without splitting, else grow the heap
    function automatic ffha_pkg::status_t grant_block(input addr_t sz, output addr_t where);
        logic [ffha_pkg::CMP_W-1:0]   grown;
        logic [ffha_pkg::LIMIT_W-1:0] ceiling;
        logic [ffha_pkg::LIMIT_W-1:0] space;
        int i;
        where = '0;
        if (sz == '0)
            return ffha_pkg::ST_NULL;
        for (i = 0; i < int'(blk_cnt); i++)
        begin
            if (blk_idle[i] && blk_len[i] >= sz)
            begin
                blk_idle[i] = 1'b0;
                where = blk_hdr[i] + addr_t'(ffha_pkg::HEADER_BYTES);
                return ffha_pkg::ST_OK;
            end
        end
        // The address space caps the ceiling even when the register is higher
        space   = ffha_pkg::LIMIT_W'(1) << ffha_pkg::ADDR_BITS;
        ceiling = (limit_now < space) ? limit_now : space;
        grown   = ffha_pkg::CMP_W'(top_now) + ffha_pkg::CMP_W'(ffha_pkg::HEADER_BYTES)
                + ffha_pkg::CMP_W'(sz);
        if (grown > ffha_pkg::CMP_W'(ceiling))
            return ffha_pkg::ST_HEAP;
        if (blk_cnt >= ffha_pkg::CNT_W'(ffha_pkg::TABLE_DEPTH))
            return ffha_pkg::ST_TABLE;
        blk_hdr[blk_cnt]  = top_now[ffha_pkg::ADDR_BITS-1:0];
        blk_len[blk_cnt]  = sz;
        blk_idle[blk_cnt] = 1'b0;
        blk_cnt           = blk_cnt + ffha_pkg::CNT_W'(1);
        where             = top_now[ffha_pkg::ADDR_BITS-1:0]
                          + addr_t'(ffha_pkg::HEADER_BYTES);
        top_now           = grown[ffha_pkg::TOP_W-1:0];
        return ffha_pkg::ST_OK;
    endfunction

    // Work out the answer to one request and advance the shadow state
    function automatic grant_t predict_grant(input logic [1:0] op, input addr_t sz,
                                             input addr_t ad);
        grant_t g;
        addr_t  where;
        int     idx;
        g.addr = '0;
        g.st   = ffha_pkg::ST_NULL;
        where  = '0;
        case (op)
            ffha_pkg::CMD_ALLOC:
            begin
                g.st   = grant_block(sz, where);
                g.addr = where;
            end
            ffha_pkg::CMD_FREE:
            begin
                if (ad != '0)
                begin
                    idx = find_live(ad);
                    if (idx < 0)
                    begin
                        g.st = ffha_pkg::ST_UNKNOWN;
                    end
                    else
                    begin
                        retire_block(idx);
                        g.st = ffha_pkg::ST_OK;
                    end
                end
            end
            ffha_pkg::CMD_REALLOC:
            begin
                if (ad == '0 || sz == '0)
                begin
                    g.st   = grant_block(sz, where);
                    g.addr = where;
                end
                else
                begin
                    idx = find_live(ad);
                    if (idx < 0)
                    begin
                        g.st = ffha_pkg::ST_UNKNOWN;
                    end
                    else if (blk_len[idx] >= sz)
                    begin
                        g.addr = ad;
                        g.st   = ffha_pkg::ST_OK;
                    end
                    else
                    begin
                        // a failed move leaves the old block where it is
                        g.st   = grant_block(sz, where);
                        g.addr = where;
                        if (g.st == ffha_pkg::ST_OK)
                            retire_block(idx);
                    end
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Random request shaping
    // ------------------------------------------------------------------

    // Data address of a random block that is in use (or free, on request)
    function automatic addr_t pick_block(input bit want_free, output bit found);
        addr_t cands[$];
        int    i;
        for (i = 0; i < int'(blk_cnt); i++)
            if (blk_idle[i] == want_free)
                cands.push_back(blk_hdr[i] + addr_t'(ffha_pkg::HEADER_BYTES));
        found = (cands.size() != 0);
        if (!found)
            return '0;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // Mostly small sizes so the table fills; a few huge ones hit the ceiling
    function automatic addr_t draw_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 12)
            return addr_t'($urandom());
        return addr_t'($urandom_range(1, 300));
    endfunction

    // Mostly live addresses; some into a block, some stale, some null or noise
    function automatic addr_t draw_addr();
        int    r;
        bit    ok;
        addr_t a;
        r = $urandom_range(0, 99);
        if (r < 88)
        begin
            a = pick_block(r >= 80, ok);
            if (r >= 70 && r < 80)
                a = a + addr_t'($urandom_range(1, 40));
            if (ok)
                return a;
        end
        if (r >= 88 && r < 94)
            return '0;
        return addr_t'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: one line each, capped so a broken run stays readable
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 200)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until the transfer, then log what it must yield.
    // Left at a rising edge, so start sees one assignment per step.
    task automatic issue_request(input logic [1:0] op, input addr_t sz, input addr_t ad,
                                 input bit known, input grant_t typed);
        grant_t want;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        req_size   <= sz;
        block_addr <= ad;
        do
            @(posedge clk);
        while (busy);
        want = predict_grant(op, sz, ad);
        if (known)
            want = typed;
        pending_grants.push_back(want);
    endtask

    task automatic random_request(input int alloc_pct);
        int         r;
        int         free_band;
        int         realloc_band;
        logic [1:0] op;
        grant_t     none;
        none.addr    = '0;
        none.st      = ffha_pkg::ST_OK;
        free_band    = (100 - alloc_pct) / 2;
        realloc_band = (100 - alloc_pct) * 2 / 5;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
            op = ffha_pkg::CMD_ALLOC;
        else if (r < alloc_pct + free_band)
            op = ffha_pkg::CMD_FREE;
        else if (r < alloc_pct + free_band + realloc_band)
            op = ffha_pkg::CMD_REALLOC;
        else
            op = CMD_UNUSED;
        if (op == CMD_UNUSED)
            issue_request(op, addr_t'($urandom()), addr_t'($urandom()), 1'b0, none);
        else
            issue_request(op, draw_size(), draw_addr(), 1'b0, none);
    endtask

    task automatic random_phase(input int items, input int alloc_pct);
        int n;
        for (n = 0; n < items; n++)
            random_request(alloc_pct);
    endtask

    // Drop start and hold off until every owed answer has arrived
    task automatic drain_requests();
        @(negedge clk);
        start <= 1'b0;
        while (pending_grants.size() != 0 || busy)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic read_heap_limit();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= HEAP_LIMIT_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(limit_now))
            flag_mismatch($sformatf("heap_limit reads %0h, want %0h", prdata, limit_now));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_heap_limit(input logic [ffha_pkg::LIMIT_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEAP_LIMIT_ADDR;
        pwdata  <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        limit_now = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_heap_limit();
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: every strobe must match the oldest owed answer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        grant_t oldest;
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
            begin
                flag_mismatch($sformatf("result %0h/%0d with nothing owed",
                                        result_addr, status));
            end
            else
            begin
                oldest = pending_grants.pop_front();
                if (result_addr !== oldest.addr)
                    flag_mismatch($sformatf("result_addr %0h, want %0h",
                                            result_addr, oldest.addr));
                if (status !== oldest.st)
                    flag_mismatch($sformatf("status %0d, want %0d", status, oldest.st));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int     k;
        grant_t typed;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = ffha_pkg::CMD_ALLOC;
        req_size   = '0;
        block_addr = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = HEAP_LIMIT_ADDR;
        pwdata     = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Ceiling must come up at its reset value
        read_heap_limit();

        // Opening script at the reset ceiling, light sender gaps
        idle_pct = 19;
        for (k = 0; k < $size(opening_script); k++)
        begin
            typed.addr = opening_script[k].exp_addr;
            typed.st   = opening_script[k].exp_st;
            issue_request(opening_script[k].op, opening_script[k].size,
                          opening_script[k].addr, opening_script[k].known, typed);
        end
        drain_requests();

        // Zero ceiling: nothing can grow, only reuse and release succeed
        write_heap_limit('0);
        random_phase(40, 45);
        drain_requests();

        // Small ceiling: heap-full answers dominate
        write_heap_limit(ffha_pkg::LIMIT_W'(4096));
        random_phase(150, 50);
        // hold off once mid-phase until the block has answered everything
        drain_requests();
        random_phase(150, 50);
        drain_requests();

        // Full 16 MiB ceiling, heavy sender gaps: the table runs full
        idle_pct = 52;
        write_heap_limit(ffha_pkg::LIMIT_RESET);
        random_phase(300, 50);
        drain_requests();

        // Random ceiling, back-to-back transfers, more releases
        idle_pct = 0;
        write_heap_limit(ffha_pkg::LIMIT_W'($urandom_range(1024, 1 << 20)));
        random_phase(290, 35);
        drain_requests();

        // Catch any stray strobe after the last answer
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ffha_pkg.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_core.sv
rtl/ffha_checker.sv
bench/tb_top.sv
